/* hw/rtl/olrb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package olrb_pkg;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_DATA  = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_STRAY    = 2'd2
	} status_t;

	localparam int unsigned ByteW = 8;

	typedef logic [ByteW-1:0] byte_t;

endpackage

`default_nettype wire

/* hw/rtl/olrb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module olrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/overwriting_log_ring_buffer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Overwriting log ring buffer: a begin item opens a message of message_length bytes
// (longer than DEPTH/2 is rejected with status 1), data items store one byte each into
// a DEPTH-entry byte RAM and overwrite the oldest bytes once the writer catches the
// reader, and read items return the next unread byte (read_valid 0 when empty). Every
// item yields exactly one result. Begin, data and unused items, and a read that finds
// the buffer empty, go straight to the output register; a read that returns a byte
// passes first through the registered read of the log RAM, and no new item is taken
// meanwhile. The next item is taken in the same cycle as the held result is drained.
// The RAM content is not cleared after reset; the pointer rules never read an entry
// before it is written, so the block is ready at once.
module overwriting_log_ring_buffer
	import olrb_pkg::*;
#(
	parameter int unsigned DEPTH = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire logic [1:0]       opcode,
	input  wire logic [ByteW-1:0] data_byte,
	input  wire logic [ByteW-1:0] message_length,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output logic      [ByteW-1:0] read_data,
	output logic                  read_valid,
	output logic      [1:0]       status
);

	localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned HalfLen = DEPTH / 2;

	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic             overrun_q;
	logic             wrapped_q;
	logic [ByteW-1:0] remain_q;

	logic             rd_pend_q;
	logic             res_valid_q;
	byte_t            res_data_q;
	logic             res_rvalid_q;
	status_t          res_status_q;

	logic             accept;
	logic             res_free;
	logic [AW-1:0]    wr_next;
	logic [AW-1:0]    rd_eff;
	logic [AW-1:0]    rd_next;
	logic             rd_hit;
	logic             too_long;
	logic             mem_we;
	logic             mem_re;
	byte_t            mem_rdata;

	// Handshake: output register is free when empty or being taken this cycle
	assign res_free   = !res_valid_q || !result_stall;
	assign item_stall = rd_pend_q || !res_free;
	assign accept     = item_valid && !item_stall;

	// Pointer arithmetic modulo DEPTH
	assign wr_next  = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
	assign rd_eff   = overrun_q ? (wrapped_q ? wr_next : '0) : rd_ptr_q;
	assign rd_next  = (rd_eff == AW'(DEPTH - 1)) ? '0 : rd_eff + AW'(1);
	assign rd_hit   = (rd_eff != wr_ptr_q);
	assign too_long = (32'(message_length) > 32'(HalfLen));

	assign mem_we = accept && (opcode == OP_DATA) && (remain_q != '0);
	assign mem_re = accept && (opcode == OP_READ) && rd_hit;

	olrb_ram #(
		.WIDTH (ByteW),
		.DEPTH (DEPTH)
	) u_log_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_ptr_q),
		.wdata (data_byte),
		.re    (mem_re),
		.raddr (rd_eff),
		.rdata (mem_rdata)
	);

	// Update pointers, flags and remaining message byte count per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			overrun_q <= 1'b0;
			wrapped_q <= 1'b0;
			remain_q  <= '0;
		end else if (accept) begin
			unique case (opcode)
				OP_BEGIN: begin
					remain_q <= too_long ? '0 : message_length;
				end
				OP_DATA: begin
					if (remain_q != '0) begin
						remain_q <= remain_q - ByteW'(1);
						wr_ptr_q <= wr_next;
						if (wr_ptr_q == AW'(DEPTH - 1)) begin
							wrapped_q <= 1'b1;
						end
						if (rd_ptr_q == wr_next) begin
							overrun_q <= 1'b1;
						end
					end
				end
				OP_READ: begin
					overrun_q <= 1'b0;
					rd_ptr_q  <= rd_hit ? rd_next : rd_eff;
				end
				default: begin
				end
			endcase
		end
	end

	// Control of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (rd_pend_q) begin
			rd_pend_q   <= 1'b0;
			res_valid_q <= 1'b1;
		end else if (accept) begin
			rd_pend_q   <= mem_re;
			res_valid_q <= !mem_re;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			res_data_q   <= mem_rdata;
			res_rvalid_q <= 1'b1;
			res_status_q <= ST_OK;
		end else if (accept) begin
			res_data_q   <= '0;
			res_rvalid_q <= 1'b0;
			unique case (opcode)
				OP_BEGIN: res_status_q <= too_long ? ST_TOO_LONG : ST_OK;
				OP_DATA:  res_status_q <= (remain_q == '0) ? ST_STRAY : ST_OK;
				default:  res_status_q <= ST_OK;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign read_data    = res_data_q;
	assign read_valid   = res_rvalid_q;
	assign status       = res_status_q;

endmodule

`default_nettype wire
